[rtl/bitmap_frame_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Bitmap frame allocator assertion macros
// Shorthand for clocked implication checks with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication
`define BFA_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication
`define BFA_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/bfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared widths, default sizes, operation codes and controller states.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int ADDR_W    = 24;
    localparam int WORD_BITS = 32;
    localparam int BIT_W     = $clog2(WORD_BITS);

    localparam int FRAME_COUNT_DEF     = 4096;
    localparam int FRAME_BYTES_DEF     = 4096;
    localparam int RESERVED_FRAMES_DEF = 256;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_MOD,
        ST_RESP
    } bfa_state_t;

endpackage

[rtl/bfa_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate or free request per transfer.
// ----------------------------------------------------------------------------
interface bfa_req_if
    import bfa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [ADDR_W-1:0] free_addr;

    modport source (output valid, output op, output free_addr, input ready);
    modport sink   (input valid, input op, input free_addr, output ready);
endinterface

[rtl/bfa_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface bfa_rsp_if
    import bfa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] frame_addr;
    logic              out_of_memory;
    logic              bad_free;

    modport source (output valid, output frame_addr, output out_of_memory,
                    output bad_free, input ready);
    modport sink   (input valid, input frame_addr, input out_of_memory,
                    input bad_free, output ready);
endinterface

[rtl/bfa_bitmap_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word memory
// Simple dual-port synchronous RAM, one write and one registered read.
// ----------------------------------------------------------------------------
module bfa_bitmap_ram
    import bfa_pkg::*;
#(
    parameter int DEPTH = FRAME_COUNT_DEF / WORD_BITS,
    parameter int WIDTH = WORD_BITS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bitmap_frame_allocator.sv]
`timescale 1ns / 1ps
// Allocate: 1..WORD_COUNT bitmap words (up to 128 by default) are examined in order, read by
// the single read port, one word read per cycle. Free: the word is read, then cleared in
// ST_FREE_MOD; a bad address skips both. A request waits until the result enters the output
// register. Reset: after rst_n rises a clearing pass over WORD_COUNT words (128 by default)
// writes the reset bitmap, reserved frames marked used; no request is taken until it ends.
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit page-frame allocator over a used-bit bitmap held in RAM.
// FRAME_BYTES must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int FRAME_COUNT     = FRAME_COUNT_DEF,
    parameter int FRAME_BYTES     = FRAME_BYTES_DEF,
    parameter int RESERVED_FRAMES = RESERVED_FRAMES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    bfa_req_if.sink   in,
    bfa_rsp_if.source out
);

    localparam int WORD_COUNT = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = $clog2(WORD_COUNT);
    localparam int FRAME_W    = WORD_AW + BIT_W;
    localparam int SHIFT      = $clog2(FRAME_BYTES);
    localparam int RES_CLAMP  = (RESERVED_FRAMES > FRAME_COUNT) ? FRAME_COUNT
                                                                : RESERVED_FRAMES;
    localparam int RES_FULL   = RES_CLAMP / WORD_BITS;
    localparam int RES_TAIL   = RES_CLAMP % WORD_BITS;
    localparam int PAD_TAIL   = FRAME_COUNT % WORD_BITS;

    localparam logic [WORD_BITS-1:0] RES_TAIL_MASK =
        (WORD_BITS'(1) << RES_TAIL) - WORD_BITS'(1);
    localparam logic [WORD_BITS-1:0] LAST_PAD_MASK = (PAD_TAIL == 0) ? '0 :
        ~((WORD_BITS'(1) << PAD_TAIL) - WORD_BITS'(1));
    localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(WORD_COUNT - 1);

    bfa_state_t state_reg, state_next;
    logic [WORD_AW-1:0] word_reg, word_next;
    logic [BIT_W-1:0]   bit_reg, bit_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next;
    logic               res_oom_reg, res_oom_next;
    logic               res_bad_reg, res_bad_next;

    logic               out_valid_reg;
    logic [ADDR_W-1:0]  out_addr_reg;
    logic               out_oom_reg;
    logic               out_bad_reg;
    logic               out_load;

    logic                 ram_we;
    logic [WORD_AW-1:0]   ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [WORD_AW-1:0]   ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic [WORD_BITS-1:0] clear_word;
    logic [WORD_BITS-1:0] scan_masked;
    logic [WORD_BITS-1:0] zero_hot;
    logic [BIT_W-1:0]     zero_idx;
    logic [ADDR_W+FRAME_W+SHIFT-1:0] alloc_prod;
    logic [31:0]          free_fnum;
    logic                 free_bad;
    logic [WORD_AW-1:0]   free_word;
    logic [BIT_W-1:0]     free_bit;
    logic [31:0]          word_ext;

    bfa_bitmap_ram #(
        .DEPTH (WORD_COUNT),
        .WIDTH (WORD_BITS),
        .AW    (WORD_AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Reset contents of the word under the clearing counter
    assign word_ext = {{(32 - WORD_AW){1'b0}}, word_reg};
    always_comb
    begin
        if (word_ext < 32'(RES_FULL))
        begin
            clear_word = '1;
        end
        else if (word_ext == 32'(RES_FULL))
        begin
            clear_word = RES_TAIL_MASK;
        end
        else
        begin
            clear_word = '0;
        end
    end

    // Lowest free bit: padding frames read as used
    assign scan_masked = ram_rdata | ((word_reg == LAST_WORD) ? LAST_PAD_MASK : '0);
    assign zero_hot    = ~scan_masked & (scan_masked + WORD_BITS'(1));

    always_comb
    begin
        zero_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (zero_hot[i])
            begin
                zero_idx = zero_idx | BIT_W'(i);
            end
        end
    end

    assign alloc_prod = {{ADDR_W{1'b0}}, word_reg, zero_idx, {SHIFT{1'b0}}};

    assign free_fnum = 32'(in.free_addr >> SHIFT);
    assign free_bad  = free_fnum >= 32'(FRAME_COUNT);
    assign free_word = free_fnum[FRAME_W-1:BIT_W];
    assign free_bit  = free_fnum[BIT_W-1:0];

    assign out_load = (state_reg == ST_RESP) && (!out_valid_reg || out.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            word_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            word_reg  <= word_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg      <= bit_next;
        res_addr_reg <= res_addr_next;
        res_oom_reg  <= res_oom_next;
        res_bad_reg  <= res_bad_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        word_next     = word_reg;
        bit_next      = bit_reg;
        res_addr_next = res_addr_reg;
        res_oom_next  = res_oom_reg;
        res_bad_next  = res_bad_reg;
        ram_we        = 1'b0;
        ram_waddr     = word_reg;
        ram_wdata     = '0;
        ram_re        = 1'b0;
        ram_raddr     = word_reg;
        in.ready      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = clear_word;
                if (word_reg == LAST_WORD)
                begin
                    word_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    word_next = word_reg + WORD_AW'(1);
                end
            end
            ST_IDLE:
            begin
                in.ready = 1'b1;
                if (in.valid)
                begin
                    res_addr_next = '0;
                    res_oom_next  = 1'b0;
                    res_bad_next  = 1'b0;
                    if (in.op == OP_ALLOC)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        word_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (free_bad)
                    begin
                        res_bad_next = 1'b1;
                        state_next   = ST_RESP;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = free_word;
                        word_next  = free_word;
                        bit_next   = free_bit;
                        state_next = ST_FREE_MOD;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_masked != '1)
                begin
                    // Claim the frame; the RAM is not read again before this lands
                    ram_we        = 1'b1;
                    ram_wdata     = ram_rdata | zero_hot;
                    res_addr_next = alloc_prod[ADDR_W-1:0];
                    state_next    = ST_RESP;
                end
                else if (word_reg == LAST_WORD)
                begin
                    res_oom_next = 1'b1;
                    state_next   = ST_RESP;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = word_reg + WORD_AW'(1);
                    word_next = word_reg + WORD_AW'(1);
                end
            end
            ST_FREE_MOD:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << bit_reg);
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: hold the result until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_addr_reg <= res_addr_reg;
            out_oom_reg  <= res_oom_reg;
            out_bad_reg  <= res_bad_reg;
        end
    end

    assign out.valid         = out_valid_reg;
    assign out.frame_addr    = out_addr_reg;
    assign out.out_of_memory = out_oom_reg;
    assign out.bad_free      = out_bad_reg;

endmodule

[rtl/bfa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap frame allocator checker
// Port-level checks on results and request flow, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_frame_allocator_defines.svh"

module bfa_checker
    import bfa_pkg::*;
#(
    parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] frame_addr,
    input logic              out_of_memory,
    input logic              bad_free
);

    localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'(FRAME_BYTES - 1);

    `BFA_ASSERT_IMP(a_oom_addr_zero, clk, rst_n, out_valid && out_of_memory,
        frame_addr == '0, "out of memory with non-zero frame address")
    `BFA_ASSERT_IMP(a_bad_free_clean, clk, rst_n, out_valid && bad_free,
        frame_addr == '0 && !out_of_memory, "bad free with allocate fields set")
    `BFA_ASSERT_IMP(a_addr_aligned, clk, rst_n, out_valid,
        (frame_addr & OFFSET_MASK) == '0, "frame address not frame aligned")
    `BFA_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && in_ready,
        !in_ready, "request taken while the previous one is in progress")
    `BFA_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(frame_addr) && $stable(out_of_memory) && $stable(bad_free),
        "stalled result changed")

endmodule

bind bitmap_frame_allocator bfa_checker #(
    .FRAME_BYTES (FRAME_BYTES)
) u_bfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in.valid),
    .in_ready      (in.ready),
    .out_valid     (out.valid),
    .out_ready     (out.ready),
    .frame_addr    (out.frame_addr),
    .out_of_memory (out.out_of_memory),
    .bad_free      (out.bad_free)
);
